### src/ssp_pkg.sv
package ssp_pkg;

  localparam int SPEED_BITS = 12;
  localparam int PULSE_BITS = 16;
  localparam int ANGLE_W    = 8;
  localparam int CMD_W      = 2;
  localparam int MDEG_W     = 18;
  localparam int CFG_INDEX_W = 1;

  localparam int MDEG_PER_DEG = 1000;
  localparam int FULL_MDEG    = 180000;
  localparam logic [ANGLE_W-1:0] FULL_DEG = ANGLE_W'(180);

  // stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = ((ANGLE_W + SPEED_BITS + 7) / 8) * 8;
  localparam int OUT_USED_W = PULSE_BITS + ANGLE_W + 1;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  // whole degrees: floor(x / 1000) = (x * ceil(2^28 / 1000)) >> 28, exact for x < 2^18
  localparam int DEG_SHIFT   = 28;
  localparam int DEG_RECIP_W = 19;
  localparam longint unsigned DEG_RECIP_L =
    ((64'd1 << DEG_SHIFT) + MDEG_PER_DEG - 1) / MDEG_PER_DEG;
  localparam logic [DEG_RECIP_W-1:0] DEG_RECIP = DEG_RECIP_W'(DEG_RECIP_L);
  localparam int DEG_PROD_W  = MDEG_W + DEG_RECIP_W;

  // compare: range * pos / 180000, done as (p >> 5) / 5625 by reciprocal
  localparam int PROD_W        = PULSE_BITS + MDEG_W;
  localparam int CMP_PRE_SHIFT = 5;
  localparam int CMP_DIV       = FULL_MDEG >> CMP_PRE_SHIFT;
  localparam int CMP_Y_W       = PROD_W - CMP_PRE_SHIFT;
  localparam int CMP_SHIFT     = 42;
  localparam int CMP_RECIP_W   = 30;
  localparam longint unsigned CMP_RECIP_L =
    ((64'd1 << CMP_SHIFT) + CMP_DIV - 1) / CMP_DIV;
  localparam logic [CMP_RECIP_W-1:0] CMP_RECIP = CMP_RECIP_W'(CMP_RECIP_L);
  localparam int QPROD_W       = CMP_Y_W + CMP_RECIP_W;

  localparam logic [PULSE_BITS-1:0] MIN_PULSE_RST = PULSE_BITS'(500);
  localparam logic [PULSE_BITS-1:0] MAX_PULSE_RST = PULSE_BITS'(2500);

  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_PULSE = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PULSE = CFG_INDEX_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_JUMP = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_TICK = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [MDEG_W-1:0]  pos_mdeg;
    logic [ANGLE_W-1:0] goal_deg;
  } pose_t;

  typedef struct packed {
    logic                  at_target;
    logic [ANGLE_W-1:0]    position_deg;
    logic [PULSE_BITS-1:0] compare_value;
  } result_t;

endpackage

### src/ssp_pulse.sv
module ssp_pulse import ssp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  pose_t                 pose_i,
  input  logic [PULSE_BITS-1:0] min_i,
  input  logic [PULSE_BITS-1:0] range_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output result_t               result_o
);

  logic                  v2_q, v3_q;
  logic                  ready2, ready3;
  logic [PROD_W-1:0]     prod_d, prod_q;
  logic [DEG_PROD_W-1:0] deg_full;
  logic [ANGLE_W-1:0]    deg_d, deg_q;
  logic [ANGLE_W-1:0]    goal_q;
  logic [CMP_Y_W-1:0]    cmp_y;
  logic [QPROD_W-1:0]    qprod;
  logic [PULSE_BITS-1:0] quot;
  result_t               res_d, res_q;

  assign ready3  = !v3_q || ready_i;
  assign ready2  = !v2_q || ready3;
  assign ready_o = ready2;

  // stage 2: pulse span product and whole-degree position
  always_comb begin
    prod_d   = PROD_W'(range_i) * PROD_W'(pose_i.pos_mdeg);
    deg_full = DEG_PROD_W'(pose_i.pos_mdeg) * DEG_PROD_W'(DEG_RECIP);
    deg_d    = deg_full[DEG_SHIFT +: ANGLE_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ready2) begin
      v2_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready2) begin
      prod_q <= prod_d;
      deg_q  <= deg_d;
      goal_q <= pose_i.goal_deg;
    end
  end

  // stage 3: divide by full scale through the reciprocal, add offset
  always_comb begin
    cmp_y               = prod_q[PROD_W-1:CMP_PRE_SHIFT];
    qprod               = QPROD_W'(cmp_y) * QPROD_W'(CMP_RECIP);
    quot                = qprod[CMP_SHIFT +: PULSE_BITS];
    res_d.compare_value = min_i + quot;
    res_d.position_deg  = deg_q;
    res_d.at_target     = (deg_q == goal_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (ready3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && ready3) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = v3_q;
  assign result_o = res_q;

endmodule

### src/servo_slew_limited_pulse_unit.sv
// channel  | direction | handshake                    | payload
// s_axis   | in        | s_axis_tvalid/s_axis_tready  | tdata angle, speed; tuser command
// m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata compare, degrees, at target
// cfg      | in        | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
// one item accepted per cycle while m_axis does not stall; an item that yields a result has it
// offered on m_axis after the input register, then ramp state, then two arithmetic stages
// the ramp state is updated as the item leaves the input register
// reset clears position, goal and step and loads the pulse limits 500 and 2500
// a stall on m_axis backs up stage by stage; cfg is always ready
module servo_slew_limited_pulse_unit import ssp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [PULSE_BITS-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,  // angle, speed
  input  logic [CMD_W-1:0]       s_axis_tuser,  // cmd
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_DATA_W-1:0]  m_axis_tdata   // compare_value, position_deg, at_target
);

  logic [PULSE_BITS-1:0] min_q, max_q, range_q, range_d;

  logic                  v0_q, v1_q;
  logic                  ready0, ready1, ready2;
  cmd_e                  cmd0_q;
  logic [ANGLE_W-1:0]    angle_raw, angle_d, angle0_q;
  logic [SPEED_BITS-1:0] speed0_q;

  logic [MDEG_W-1:0]     pos_q, pos_d, goal_m_q, goal_m_d, angle_m, gap, step_ext;
  logic [ANGLE_W-1:0]    goal_q, goal_d;
  logic [SPEED_BITS-1:0] step_q, step_d;
  logic                  below, at_deg, emit, jump, advance;

  pose_t                 pose;
  result_t               result;

  // configuration
  assign cfg_ready_o = 1'b1;
  assign range_d     = (max_q >= min_q) ? (max_q - min_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= MIN_PULSE_RST;
      max_q   <= MAX_PULSE_RST;
      range_q <= MAX_PULSE_RST - MIN_PULSE_RST;
    end else begin
      range_q <= range_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_MIN_PULSE: min_q <= cfg_data_i;
          CFG_MAX_PULSE: max_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // input register
  assign ready1        = !v1_q || ready2;
  assign ready0        = !v0_q || ready1;
  assign s_axis_tready = ready0;
  assign advance       = v0_q && ready1;

  assign angle_raw = s_axis_tdata[ANGLE_W-1:0];
  assign angle_d   = (angle_raw > FULL_DEG) ? FULL_DEG : angle_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (ready0) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && ready0) begin
      cmd0_q   <= cmd_e'(s_axis_tuser);
      angle0_q <= angle_d;
      speed0_q <= s_axis_tdata[ANGLE_W +: SPEED_BITS];
    end
  end

  // ramp update
  always_comb begin
    angle_m  = MDEG_W'(angle0_q * MDEG_PER_DEG);
    step_ext = MDEG_W'(step_q);
    below    = (pos_q < goal_m_q);
    gap      = below ? (goal_m_q - pos_q) : (pos_q - goal_m_q);
    // whole-degree part equals the goal when pos sits in [goal, goal + 1 deg)
    at_deg   = !below && (gap < MDEG_W'(MDEG_PER_DEG));

    pos_d    = pos_q;
    goal_d   = goal_q;
    goal_m_d = goal_m_q;
    step_d   = step_q;
    emit     = 1'b0;
    jump     = 1'b0;

    case (cmd0_q)
      CMD_JUMP: jump = 1'b1;
      CMD_MOVE: begin
        if (speed0_q == '0) begin
          jump = 1'b1;
        end else begin
          goal_d   = angle0_q;
          goal_m_d = angle_m;
          step_d   = speed0_q;
        end
      end
      CMD_TICK: begin
        if (step_q != '0 && !at_deg) begin
          emit = 1'b1;
          if (gap <= step_ext) begin
            pos_d = goal_m_q;
          end else if (below) begin
            pos_d = pos_q + step_ext;
          end else begin
            pos_d = pos_q - step_ext;
          end
        end
      end
      default: ;
    endcase

    if (jump) begin
      goal_d   = angle0_q;
      goal_m_d = angle_m;
      pos_d    = angle_m;
      step_d   = '0;
      emit     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      goal_q   <= '0;
      goal_m_q <= '0;
      step_q   <= '0;
    end else if (advance) begin
      pos_q    <= pos_d;
      goal_q   <= goal_d;
      goal_m_q <= goal_m_d;
      step_q   <= step_d;
    end
  end

  // the ramp state itself is the stage payload: it only changes when this stage moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ready1) begin
      v1_q <= v0_q && emit;
    end
  end

  assign pose.pos_mdeg = pos_q;
  assign pose.goal_deg = goal_q;

  ssp_pulse u_pulse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v1_q),
    .ready_o  (ready2),
    .pose_i   (pose),
    .min_i    (min_q),
    .range_i  (range_q),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (result)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, result.at_target, result.position_deg,
                         result.compare_value};

endmodule

### src/ssp_checker.sv
module ssp_checker import ssp_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // no result shows while reset is held
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // position never leaves the servo span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[PULSE_BITS +: ANGLE_W] <= FULL_DEG))
    else $error("position above full span");

  // padding stays clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:OUT_USED_W] == '0))
    else $error("padding bits set");

  // a stalled transaction stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result dropped or changed");

endmodule

bind servo_slew_limited_pulse_unit ssp_checker u_checker (.*);

### dv/servo_slew_limited_pulse_unit_tb.sv
module servo_slew_limited_pulse_unit_tb;
  import ssp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int NUM_PHASES    = 7;
  localparam int PHASE_ITEMS   = 275;
  localparam int SETTLE_CYCLES = 16;
  localparam int PLAN_LEN      = 27;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_KNOWN,
    ROW_RANGE
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CMD_W-1:0]      cmd;
    logic [ANGLE_W-1:0]    angle;
    logic [SPEED_BITS-1:0] speed;
    result_t               want;
    logic [PULSE_BITS-1:0] lo;
    logic [PULSE_BITS-1:0] hi;
  } row_t;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i   = '0;
  logic [PULSE_BITS-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
  logic [CMD_W-1:0]       s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;

  // sideband that travels with the driven item: a typed-in expectation
  logic                   known_q   = 1'b0;
  result_t                known_res = '0;

  // servo model state and pulse limits
  logic [MDEG_W-1:0]      pos_mdeg_m  = '0;
  logic [ANGLE_W-1:0]     goal_deg_m  = '0;
  logic [SPEED_BITS-1:0]  step_mdeg_m = '0;
  logic [PULSE_BITS-1:0]  min_pulse_m = MIN_PULSE_RST;
  logic [PULSE_BITS-1:0]  max_pulse_m = MAX_PULSE_RST;

  result_t pending_pulses[$];
  int      fail_count     = 0;
  int      pulses_checked = 0;
  int      items_sent     = 0;
  int      ranges_used    = 0;
  int      src_idle_pct   = 20;
  int      snk_stall_pct  = 20;
  int      stall_left     = 0;

  row_t plan [PLAN_LEN];

  servo_slew_limited_pulse_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // advances the ramp by one command; returns 1 when a new compare value comes out
  function automatic bit ramp_predict(input logic [CMD_W-1:0] cmd,
                                      input logic [ANGLE_W-1:0] raw_angle,
                                      input logic [SPEED_BITS-1:0] speed,
                                      output result_t res);
    logic [ANGLE_W-1:0] angle;
    int unsigned        goal_m;
    int unsigned        deg;
    longint unsigned    span;
    longint unsigned    cmp;
    res   = '0;
    angle = (raw_angle > FULL_DEG) ? FULL_DEG : raw_angle;
    if (cmd == CMD_JUMP || (cmd == CMD_MOVE && speed == '0)) begin
      goal_deg_m  = angle;
      pos_mdeg_m  = MDEG_W'(int'(angle) * MDEG_PER_DEG);
      step_mdeg_m = '0;
    end else if (cmd == CMD_MOVE) begin
      goal_deg_m  = angle;
      step_mdeg_m = speed;
      return 1'b0;
    end else if (cmd == CMD_TICK) begin
      if (step_mdeg_m == '0 || int'(pos_mdeg_m) / MDEG_PER_DEG == int'(goal_deg_m))
        return 1'b0;
      goal_m = int'(goal_deg_m) * MDEG_PER_DEG;
      if (pos_mdeg_m < goal_m) begin
        if (goal_m - pos_mdeg_m <= step_mdeg_m) pos_mdeg_m = MDEG_W'(goal_m);
        else pos_mdeg_m = pos_mdeg_m + step_mdeg_m;
      end else begin
        if (pos_mdeg_m - goal_m <= step_mdeg_m) pos_mdeg_m = MDEG_W'(goal_m);
        else pos_mdeg_m = pos_mdeg_m - step_mdeg_m;
      end
    end else begin
      return 1'b0;
    end
    deg  = int'(pos_mdeg_m) / MDEG_PER_DEG;
    span = (max_pulse_m >= min_pulse_m) ? 64'(max_pulse_m - min_pulse_m) : 64'd0;
    cmp  = 64'(min_pulse_m) + (span * 64'(pos_mdeg_m)) / 64'(FULL_MDEG);
    res.compare_value = cmp[PULSE_BITS-1:0];
    res.position_deg  = ANGLE_W'(deg);
    res.at_target     = (deg == int'(goal_deg_m));
    return 1'b1;
  endfunction

  task automatic check_pulse(input result_t got);
    result_t want;
    if (pending_pulses.size() == 0) begin
      $error("result with nothing expected: compare_value %0d position_deg %0d at_target %0b",
             got.compare_value, got.position_deg, got.at_target);
      fail_count++;
      return;
    end
    want = pending_pulses.pop_front();
    pulses_checked++;
    if (got.compare_value !== want.compare_value) begin
      $error("compare_value: expected %0d, got %0d", want.compare_value, got.compare_value);
      fail_count++;
    end
    if (got.position_deg !== want.position_deg) begin
      $error("position_deg: expected %0d, got %0d", want.position_deg, got.position_deg);
      fail_count++;
    end
    if (got.at_target !== want.at_target) begin
      $error("at_target: expected %0b, got %0b", want.at_target, got.at_target);
      fail_count++;
    end
  endtask

  function automatic int pick_gap(input int pct);
    if ($urandom_range(99, 0) >= pct) return 0;
    if ($urandom_range(9, 0) == 0) return $urandom_range(40, 8);
    return $urandom_range(3, 1);
  endfunction

  // one place watches every handshake, so pushes and pops never race
  always @(posedge clk_i) begin
    result_t res;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_MIN_PULSE) min_pulse_m = cfg_data_i;
        else if (cfg_index_i == CFG_MAX_PULSE) max_pulse_m = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (ramp_predict(s_axis_tuser, s_axis_tdata[ANGLE_W-1:0],
                         s_axis_tdata[ANGLE_W +: SPEED_BITS], res))
          pending_pulses.push_back(known_q ? known_res : res);
      end
      if (m_axis_tvalid && m_axis_tready)
        check_pulse(result_t'(m_axis_tdata[OUT_USED_W-1:0]));
    end
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left    <= pick_gap(snk_stall_pct);
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ANGLE_W-1:0] angle,
                           input logic [SPEED_BITS-1:0] speed, input logic known,
                           input result_t want);
    int gap;
    gap = pick_gap(src_idle_pct);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= IN_DATA_W'({speed, angle});
    known_q       <= known;
    known_res     <= want;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // quiet the input and let every outstanding compare value come out
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    // the last accepted transaction is queued by the monitor at the edge just seen
    @(posedge clk_i);
    while (pending_pulses.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_pulse_range(input logic [PULSE_BITS-1:0] lo,
                                 input logic [PULSE_BITS-1:0] hi);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_MIN_PULSE;
    cfg_data_i  <= lo;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_MAX_PULSE;
    cfg_data_i  <= hi;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    ranges_used++;
  endtask

  function automatic logic [SPEED_BITS-1:0] pick_speed();
    case ($urandom_range(2, 0))
      0: return SPEED_BITS'($urandom_range(4095, 1));
      1: return SPEED_BITS'($urandom_range(4095, 2000));
      default: return SPEED_BITS'($urandom_range(300, 1));
    endcase
  endfunction

  function automatic logic [ANGLE_W-1:0] pick_angle();
    if ($urandom_range(99, 0) < 15) return ANGLE_W'($urandom_range(255, 181));
    return ANGLE_W'($urandom_range(180, 0));
  endfunction

  function automatic row_t row_item(input logic [CMD_W-1:0] cmd,
                                    input logic [ANGLE_W-1:0] angle,
                                    input logic [SPEED_BITS-1:0] speed);
    row_t r;
    r       = '0;
    r.kind  = ROW_PREDICT;
    r.cmd   = cmd;
    r.angle = angle;
    r.speed = speed;
    return r;
  endfunction

  function automatic row_t row_known(input logic [CMD_W-1:0] cmd,
                                     input logic [ANGLE_W-1:0] angle,
                                     input logic [SPEED_BITS-1:0] speed,
                                     input logic [PULSE_BITS-1:0] cmp,
                                     input logic [ANGLE_W-1:0] deg, input logic at);
    row_t r;
    r      = row_item(cmd, angle, speed);
    r.kind = ROW_KNOWN;
    r.want = '{at_target: at, position_deg: deg, compare_value: cmp};
    return r;
  endfunction

  function automatic row_t row_range(input logic [PULSE_BITS-1:0] lo,
                                     input logic [PULSE_BITS-1:0] hi);
    row_t r;
    r      = '0;
    r.kind = ROW_RANGE;
    r.lo   = lo;
    r.hi   = hi;
    return r;
  endfunction

  initial begin
    logic [PULSE_BITS-1:0] lo;
    logic [PULSE_BITS-1:0] hi;
    int                    stop_at;
    int                    legs;
    plan = '{
      row_known(CMD_JUMP, 8'd0,   12'd0,    16'd500,   8'd0,   1'b1),
      row_known(CMD_JUMP, 8'd255, 12'd0,    16'd2500,  8'd180, 1'b1),
      row_known(CMD_JUMP, 8'd181, 12'd4095, 16'd2500,  8'd180, 1'b1),
      row_known(CMD_JUMP, 8'd90,  12'd0,    16'd1500,  8'd90,  1'b1),
      row_item (CMD_TICK, 8'd0,   12'd0),
      row_known(CMD_MOVE, 8'd45,  12'd0,    16'd1000,  8'd45,  1'b1),
      row_item (CMD_MOVE, 8'd0,   12'd4095),
      row_item (CMD_TICK, 8'd0,   12'd0),
      row_item (CMD_MOVE, 8'd255, 12'd4095),
      row_item (CMD_TICK, 8'd0,   12'd0),
      row_item (CMD_UNUSED, 8'd255, 12'd4095),
      row_known(CMD_JUMP, 8'd94,  12'd0,    16'd1544,  8'd94,  1'b1),
      // ramp up, clamp on the goal, then an idle tick
      row_item (CMD_MOVE, 8'd95,  12'd400),
      row_item (CMD_TICK, 8'd0,   12'd0),
      row_item (CMD_TICK, 8'd0,   12'd0),
      row_item (CMD_TICK, 8'd0,   12'd0),
      row_item (CMD_TICK, 8'd0,   12'd0),
      // ramp down; stops once whole degrees match, short of the exact goal
      row_item (CMD_MOVE, 8'd93,  12'd500),
      row_item (CMD_TICK, 8'd0,   12'd0),
      row_item (CMD_TICK, 8'd0,   12'd0),
      row_item (CMD_TICK, 8'd0,   12'd0),
      row_item (CMD_TICK, 8'd0,   12'd0),
      row_range(16'd65535, 16'd0),
      row_known(CMD_JUMP, 8'd90,  12'd0,    16'd65535, 8'd90,  1'b1),
      row_range(16'd0, 16'd65535),
      row_known(CMD_JUMP, 8'd180, 12'd0,    16'd65535, 8'd180, 1'b1),
      row_known(CMD_JUMP, 8'd0,   12'd0,    16'd0,     8'd0,   1'b1)
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_RANGE) begin
        settle();
        set_pulse_range(plan[i].lo, plan[i].hi);
      end else begin
        send_item(plan[i].cmd, plan[i].angle, plan[i].speed,
                  plan[i].kind == ROW_KNOWN, plan[i].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin lo = MIN_PULSE_RST; hi = MAX_PULSE_RST; end
        1: begin lo = 16'd65535; hi = 16'd0; end
        2: begin lo = 16'd0; hi = 16'd65535; end
        3: begin lo = 16'd65535; hi = 16'd65535; end
        4: begin
          lo = PULSE_BITS'($urandom_range(32767, 0));
          hi = PULSE_BITS'($urandom_range(65535, 32768));
        end
        5: begin lo = 16'd0; hi = 16'd0; end
        default: begin
          lo = PULSE_BITS'($urandom_range(65535, 0));
          hi = PULSE_BITS'($urandom_range(65535, 0));
        end
      endcase
      settle();
      set_pulse_range(lo, hi);
      src_idle_pct  = (ph % 3 == 2) ? 0 : 30;
      snk_stall_pct = (ph % 3 == 1) ? 0 : 30;
      stop_at       = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) begin
        if ($urandom_range(99, 0) < 80) begin
          // anchor the position, then one or more ramps with a run of ticks
          if ($urandom_range(1, 0) == 1)
            send_item(CMD_JUMP, pick_angle(), SPEED_BITS'($urandom_range(4095, 0)),
                      1'b0, '0);
          else
            send_item(CMD_MOVE, pick_angle(), '0, 1'b0, '0);
          legs = $urandom_range(3, 1);
          repeat (legs) begin
            if (items_sent < stop_at)
              send_item(CMD_MOVE, pick_angle(), pick_speed(), 1'b0, '0);
            repeat ($urandom_range(60, 1))
              if (items_sent < stop_at)
                send_item(CMD_TICK, ANGLE_W'($urandom_range(255, 0)),
                          SPEED_BITS'($urandom_range(4095, 0)), 1'b0, '0);
          end
        end else begin
          send_item(CMD_W'($urandom_range(3, 0)), ANGLE_W'($urandom_range(255, 0)),
                    SPEED_BITS'($urandom_range(4095, 0)), 1'b0, '0);
        end
      end
    end

    settle();
    if (pending_pulses.size() != 0) begin
      $error("%0d expected compare values never arrived", pending_pulses.size());
      fail_count++;
    end
    $display("sent %0d commands (jump, move, tick, unused) under %0d pulse ranges",
             items_sent, ranges_used);
    $display("checked %0d compare values, %0d mismatches", pulses_checked, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
src/ssp_pkg.sv
src/ssp_pulse.sv
src/servo_slew_limited_pulse_unit.sv
src/ssp_checker.sv
dv/servo_slew_limited_pulse_unit_tb.sv
